// File: rtl/triangle_face_normal_assert.svh
// assertion macros for the triangle face normal block
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// condition holds at every edge out of reset
`define TFN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TFN_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/tfn_pkg.sv
// shared widths and pipeline beat types for the triangle face normal block
package tfn_pkg;

  localparam int CRD_W   = 24;   // Q12.12 coordinate
  localparam int EDGE_W  = 25;   // vertex difference
  localparam int CROSS_W = 50;   // cross product component, signed
  localparam int MAG_W   = 49;   // cross product magnitude
  localparam int HALF_W  = 24;   // low part of the magnitude split
  localparam int SQ_W    = 98;   // magnitude squared
  localparam int SUM_W   = 100;  // squared length
  localparam int DW      = 136;  // residual and running term width
  localparam int FRAC_SH = 32;   // (2 * 2^15)^2 scale of the test
  localparam int KW      = 15;   // output magnitude bits
  localparam int NRM_W   = 16;   // Q1.15 output
  localparam int NUM_CRD = 9;
  localparam int NUM_AX  = 3;

  localparam logic [NRM_W-1:0] NRM_MIN = {1'b1, {(NRM_W-1){1'b0}}};

  typedef logic signed [CROSS_W-1:0] cross_val_t;
  typedef logic signed [DW-1:0]      wide_t;

  typedef struct packed {
    logic                    valid;
    cross_val_t [NUM_AX-1:0] c;
  } cross_beat_t;

  typedef struct packed {
    logic                         valid;
    logic                         deg;
    logic [NUM_AX-1:0]            neg;
    logic [SUM_W-1:0]             s;
    wide_t [NUM_AX-1:0]           d;
    wide_t [NUM_AX-1:0]           t;
    logic [NUM_AX-1:0][KW-1:0]    k;
  } iter_beat_t;

endpackage

// File: rtl/tfn_cross.sv
// edge vectors and cross product, three register stages
module tfn_cross
  import tfn_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [NUM_CRD-1:0][CRD_W-1:0]   crd,
  output cross_beat_t                     out_beat
);

  logic                      v1_r, v2_r, v3_r;
  logic signed [EDGE_W-1:0]  edge_nxt [6];
  logic signed [EDGE_W-1:0]  edge_r   [6];
  logic signed [CROSS_W-1:0] prod_r   [6];
  cross_val_t                cr_r     [NUM_AX];

  // edge a = p1 - p0 in slots 0..2, edge b = p2 - p0 in slots 3..5
  always_comb begin
    for (int i = 0; i < NUM_AX; i++) begin
      edge_nxt[i]   = $signed({crd[i+3][CRD_W-1], crd[i+3]})
                    - $signed({crd[i][CRD_W-1], crd[i]});
      edge_nxt[i+3] = $signed({crd[i+6][CRD_W-1], crd[i+6]})
                    - $signed({crd[i][CRD_W-1], crd[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    edge_r    <= edge_nxt;
    prod_r[0] <= edge_r[1] * edge_r[5];
    prod_r[1] <= edge_r[2] * edge_r[4];
    prod_r[2] <= edge_r[2] * edge_r[3];
    prod_r[3] <= edge_r[0] * edge_r[5];
    prod_r[4] <= edge_r[0] * edge_r[4];
    prod_r[5] <= edge_r[1] * edge_r[3];
    for (int i = 0; i < NUM_AX; i++) begin
      cr_r[i] <= prod_r[2*i] - prod_r[2*i+1];
    end
  end

  always_comb begin
    out_beat.valid = v3_r;
    for (int i = 0; i < NUM_AX; i++) begin
      out_beat.c[i] = cr_r[i];
    end
  end

endmodule

// File: rtl/tfn_prep.sv
// magnitudes, split squares, squared length and the start of the rounding search
module tfn_prep
  import tfn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cross_beat_t in_beat,
  output iter_beat_t  out_beat
);

  logic                    v4_r, v5_r, v6_r, v7_r, v8_r;
  logic [NUM_AX-1:0]       neg4_r, neg5_r, neg6_r, neg7_r;
  logic                    deg4_r, deg5_r, deg6_r, deg7_r;
  cross_val_t              cabs [NUM_AX];
  logic [MAG_W-1:0]        mag_nxt [NUM_AX];
  logic [MAG_W-1:0]        mag_r   [NUM_AX];
  logic [2*(MAG_W-HALF_W)-1:0] hh_r [NUM_AX];
  logic [MAG_W-1:0]        hl_r [NUM_AX];
  logic [2*HALF_W-1:0]     ll_r [NUM_AX];
  logic [SQ_W-1:0]         sq_r  [NUM_AX];
  logic [SQ_W-1:0]         sq7_r [NUM_AX];
  logic [SUM_W-1:0]        s7_r;
  iter_beat_t              pay_nxt, pay_r;

  always_comb begin
    for (int i = 0; i < NUM_AX; i++) begin
      cabs[i]    = in_beat.c[i][CROSS_W-1] ? -in_beat.c[i] : in_beat.c[i];
      mag_nxt[i] = cabs[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v4_r <= in_beat.valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AX; i++) begin
      neg4_r[i] <= in_beat.c[i][CROSS_W-1];
      mag_r[i]  <= mag_nxt[i];
      // a^2 from three narrow partial products
      hh_r[i]   <= mag_r[i][MAG_W-1:HALF_W] * mag_r[i][MAG_W-1:HALF_W];
      hl_r[i]   <= mag_r[i][MAG_W-1:HALF_W] * mag_r[i][HALF_W-1:0];
      ll_r[i]   <= mag_r[i][HALF_W-1:0] * mag_r[i][HALF_W-1:0];
      sq_r[i]   <= (SQ_W'(hh_r[i]) << (2*HALF_W)) + (SQ_W'(hl_r[i]) << (HALF_W+1))
                 + SQ_W'(ll_r[i]);
      sq7_r[i]  <= sq_r[i];
    end
    deg4_r <= (in_beat.c == '0);
    neg5_r <= neg4_r;
    neg6_r <= neg5_r;
    neg7_r <= neg6_r;
    deg5_r <= deg4_r;
    deg6_r <= deg5_r;
    deg7_r <= deg6_r;
    s7_r   <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    pay_r  <= pay_nxt;
  end

  // residual d = a^2 * 2^32 - S and running term t = S * (2k - 1) at k = 0
  always_comb begin
    pay_nxt       = '0;
    pay_nxt.deg   = deg7_r;
    pay_nxt.neg   = neg7_r;
    pay_nxt.s     = s7_r;
    for (int i = 0; i < NUM_AX; i++) begin
      pay_nxt.d[i] = (DW'(sq7_r[i]) << FRAC_SH) - DW'(s7_r);
      pay_nxt.t[i] = DW'(0) - DW'(s7_r);
    end
  end

  always_comb begin
    out_beat       = pay_r;
    out_beat.valid = v8_r;
  end

endmodule

// File: rtl/tfn_bit_stage.sv
// one output bit of the exact rounding search, all three axes
module tfn_bit_stage
  import tfn_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  iter_beat_t in_beat,
  output iter_beat_t out_beat
);

  logic       vld_r;
  wide_t      trial [NUM_AX];
  iter_beat_t pay_nxt, pay_r;

  // setting this bit adds S * (2^(b+2) * (2k-1) + 2^(2b+2)) to (2k-1)^2 * S
  always_comb begin
    pay_nxt = in_beat;
    for (int i = 0; i < NUM_AX; i++) begin
      trial[i] = in_beat.d[i] - (in_beat.t[i] << (BIT + 2))
               - (DW'(in_beat.s) << (2*BIT + 2));
      if (!trial[i][DW-1]) begin
        pay_nxt.d[i]      = trial[i];
        pay_nxt.t[i]      = in_beat.t[i] + (DW'(in_beat.s) << (BIT + 1));
        pay_nxt.k[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
  end

  always_comb begin
    out_beat       = pay_r;
    out_beat.valid = vld_r;
  end

endmodule

// File: rtl/triangle_face_normal.sv
// triangle face normal: each start beat yields one out_valid strobe with its normal
// throughput one triangle per cycle, busy is never raised and start may stay high
// cross product, then squares and length, then a bit stage per output bit, then output
// the receiver cannot stall; every beat leaves exactly once, in order
// synchronous active-low reset clears every valid bit, payload is not reset
`include "triangle_face_normal_assert.svh"

module triangle_face_normal
  import tfn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CRD_W-1:0] in_p0_x,
  input  logic signed [CRD_W-1:0] in_p0_y,
  input  logic signed [CRD_W-1:0] in_p0_z,
  input  logic signed [CRD_W-1:0] in_p1_x,
  input  logic signed [CRD_W-1:0] in_p1_y,
  input  logic signed [CRD_W-1:0] in_p1_z,
  input  logic signed [CRD_W-1:0] in_p2_x,
  input  logic signed [CRD_W-1:0] in_p2_y,
  input  logic signed [CRD_W-1:0] in_p2_z,
  output logic                    out_valid,
  output logic signed [NRM_W-1:0] out_normal_x,
  output logic signed [NRM_W-1:0] out_normal_y,
  output logic signed [NRM_W-1:0] out_normal_z,
  output logic                    out_degenerate
);

  logic [NUM_CRD-1:0][CRD_W-1:0] crd;
  cross_beat_t                   cross_beat;
  iter_beat_t                    chain [KW+1];
  iter_beat_t                    fin;
  logic [NRM_W-1:0]              kx [NUM_AX];
  logic [NUM_AX-1:0][NRM_W-1:0]  nrm_nxt, nrm_r;
  logic                          out_valid_r, deg_r;
  logic                          nrm_zero, nrm_bad, deg_beat, nrm_beat;

  assign busy = 1'b0;
  assign crd  = {in_p2_z, in_p2_y, in_p2_x, in_p1_z, in_p1_y, in_p1_x,
                 in_p0_z, in_p0_y, in_p0_x};

  tfn_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .crd      (crd),
    .out_beat (cross_beat)
  );

  tfn_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (cross_beat),
    .out_beat (chain[0])
  );

  for (genvar g = 0; g < KW; g++) begin : g_bit
    tfn_bit_stage #(.BIT(KW - 1 - g)) u_bit (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_beat  (chain[g]),
      .out_beat (chain[g+1])
    );
  end

  assign fin = chain[KW];

  // apply the sign; a zero cross product forces a zero normal
  always_comb begin
    for (int i = 0; i < NUM_AX; i++) begin
      kx[i]      = {1'b0, fin.k[i]};
      nrm_nxt[i] = fin.deg ? '0 : (fin.neg[i] ? -kx[i] : kx[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    nrm_r <= nrm_nxt;
    deg_r <= fin.deg;
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_degenerate = deg_r;

  assign nrm_zero = (out_normal_x == '0) && (out_normal_y == '0) && (out_normal_z == '0);
  assign nrm_bad  = out_valid && ((out_normal_x == NRM_MIN) || (out_normal_y == NRM_MIN) ||
                                  (out_normal_z == NRM_MIN));
  assign deg_beat = out_valid && out_degenerate;
  assign nrm_beat = out_valid && !out_degenerate;

  `TFN_ASSERT_IMPLY(a_degenerate_zero, deg_beat, nrm_zero, "degenerate beat, nonzero normal")
  `TFN_ASSERT_IMPLY(a_normal_nonzero, nrm_beat, !nrm_zero, "zero normal, degenerate flag low")
  `TFN_ASSERT_ALWAYS(a_no_min_code, !nrm_bad, "normal component outside the clamp range")

endmodule

// File: bench/tb_triangle_face_normal.sv
// self-checking testbench for the triangle face normal block
`timescale 1ns / 1ps

module tb_triangle_face_normal;
  import tfn_pkg::*;

  typedef logic signed [CRD_W-1:0] tri_t [NUM_CRD];

  typedef struct {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    deg;
  } normal_t;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam logic signed [CRD_W-1:0] CMAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic signed [CRD_W-1:0] CMIN = {1'b1, {(CRD_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CRD_W-1:0] crd [NUM_CRD];
  logic out_valid;
  logic signed [NRM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;

  normal_t normals_due [$];
  int  idle_pct = 0;
  int  n_errors = 0;
  int  quiet_cycles = 0;

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < NUM_CRD; i++) crd[i] = '0;
  end

  triangle_face_normal DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_p0_x(crd[0]), .in_p0_y(crd[1]), .in_p0_z(crd[2]),
    .in_p1_x(crd[3]), .in_p1_y(crd[4]), .in_p1_z(crd[5]),
    .in_p2_x(crd[6]), .in_p2_y(crd[7]), .in_p2_z(crd[8]),
    .out_valid(out_valid), .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate)
  );

  // largest k with (2k-1)^2 * len2 <= mag^2 * 2^32, sign of the cross term
  function automatic logic signed [NRM_W-1:0] unit_component(longint c, logic [159:0] len2);
    logic [159:0] mag, rhs, odd;
    int lo, hi, mid;
    mag = (c < 0) ? 160'(-c) : 160'(c);
    rhs = (mag * mag) << 32;
    lo = 0;
    hi = 32767;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 160'(2 * mid - 1);
      if (odd * odd * len2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? -NRM_W'(lo) : NRM_W'(lo);
  endfunction

  function automatic normal_t face_normal(tri_t p);
    longint ax, ay, az, bx, by, bz;
    longint cr [3];
    logic [159:0] len2;
    normal_t n;
    ax = longint'(p[3]) - longint'(p[0]);
    ay = longint'(p[4]) - longint'(p[1]);
    az = longint'(p[5]) - longint'(p[2]);
    bx = longint'(p[6]) - longint'(p[0]);
    by = longint'(p[7]) - longint'(p[1]);
    bz = longint'(p[8]) - longint'(p[2]);
    cr[0] = ay * bz - az * by;
    cr[1] = az * bx - ax * bz;
    cr[2] = ax * by - ay * bx;
    n = '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
    if (cr[0] != 0 || cr[1] != 0 || cr[2] != 0) begin
      len2 = '0;
      for (int i = 0; i < 3; i++) begin
        len2 += 160'(cr[i] < 0 ? -cr[i] : cr[i]) * 160'(cr[i] < 0 ? -cr[i] : cr[i]);
      end
      n.nx = unit_component(cr[0], len2);
      n.ny = unit_component(cr[1], len2);
      n.nz = unit_component(cr[2], len2);
      n.deg = 1'b0;
    end
    return n;
  endfunction

  task automatic send_triangle(tri_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    for (int i = 0; i < NUM_CRD; i++) crd[i] <= p[i];
    @(posedge clk);
    while (busy) @(posedge clk);
    normals_due.push_back(face_normal(p));
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    normal_t e;
    if (rst_n && out_valid) begin
      if (normals_due.size() == 0) begin
        $display("%0t: unexpected beat nx=%0d ny=%0d nz=%0d deg=%0b", $time,
                 out_normal_x, out_normal_y, out_normal_z, out_degenerate);
        n_errors++;
      end else begin
        e = normals_due.pop_front();
        if (out_normal_x !== e.nx || out_normal_y !== e.ny || out_normal_z !== e.nz ||
            out_degenerate !== e.deg) begin
          $display("%0t: expected nx=%0d ny=%0d nz=%0d deg=%0b, got nx=%0d ny=%0d nz=%0d deg=%0b",
                   $time, e.nx, e.ny, e.nz, e.deg,
                   out_normal_x, out_normal_y, out_normal_z, out_degenerate);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic tri_t make_tri(logic signed [CRD_W-1:0] a0, a1, a2, b0, b1, b2,
                                    c0, c1, c2);
    tri_t p;
    p = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return p;
  endfunction

  task automatic test_directed();
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));              // coincident
    send_triangle(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
    send_triangle(make_tri(0, 0, 0, 1, 1, 1, 7, 7, 7));              // collinear
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));              // component near one
    send_triangle(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    send_triangle(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
    send_triangle(make_tri(0, 0, 0, 1, 1, 0, 0, 0, 1));
    send_triangle(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
    send_triangle(make_tri(CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN));
    send_triangle(make_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX));
    send_triangle(make_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    send_triangle(make_tri(CMAX, 0, CMIN, 0, CMAX, 0, CMIN, 0, CMAX));
    send_triangle(make_tri(-1, -1, -1, 1, 2, 3, -4, 5, -6));
    send_triangle(make_tri(0, 0, 0, 1000, 1, 0, 0, 1000, 1));
    release_start();
  endtask

  task automatic test_random(int n_items, int pct);
    tri_t p;
    int m;
    idle_pct = pct;
    for (int k = 0; k < n_items; k++) begin
      for (int i = 0; i < NUM_CRD; i++) p[i] = CRD_W'($urandom);
      case ($urandom_range(5))
        0: for (int i = 3; i < NUM_CRD; i++)                      // small triangle near p0
             p[i] = p[i % 3] + CRD_W'($signed($urandom_range(16)) - 8);
        1: begin                                                   // collinear
          m = $signed($urandom_range(6)) - 3;
          for (int i = 0; i < 3; i++) begin
            p[i + 3] = p[i] + CRD_W'($signed($urandom_range(200)) - 100);
            p[i + 6] = p[i] + CRD_W'(m) * (p[i + 3] - p[i]);
          end
        end
        2: begin                                                   // nearly axis aligned
          p[5] = p[2] + CRD_W'($urandom_range(2));
          p[8] = p[2] + CRD_W'($urandom_range(2));
        end
        3: for (int i = 0; i < NUM_CRD; i++)
             if ($urandom_range(1)) p[i] = $urandom_range(1) ? CMAX : CMIN;
        default: ;
      endcase
      send_triangle(p);
    end
    release_start();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(385, 0);
    test_random(385, 49);
    test_random(385, 35);
    test_random(385, 0);
    while (normals_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_prep.sv
rtl/tfn_bit_stage.sv
rtl/triangle_face_normal.sv
bench/tb_triangle_face_normal.sv
